// File: hw/rtl/register_file_alu_with_flags_top_macros.svh
// ----------------------------------------------------------------------------
// Register file ALU assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REGISTER_FILE_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define REGISTER_FILE_ALU_WITH_FLAGS_TOP_MACROS_SVH

// same-cycle implication
`define RFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// Register file ALU package
// Operation codes, flag layout and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CMP   = 3'd4,
        OP_MOV   = 3'd5,
        OP_READ  = 3'd6,
        OP_WRITE = 3'd7
    } t_op;

    typedef struct packed {
        logic sign;
        logic zero;
        logic ovf;
    } t_flags;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul_wb;
        logic div_start;
        logic div_wb;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic div_zero;
        logic div_done;
    } t_status;

endpackage

// File: hw/rtl/rfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports sharing a read enable, registered read data.
// ----------------------------------------------------------------------------
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: hw/rtl/rfa_div.sv
// ----------------------------------------------------------------------------
// Signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rfa_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [rfa_pkg::DATA_W-1:0] i_dividend,
    input  logic signed [rfa_pkg::DATA_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [rfa_pkg::DATA_W-1:0]       o_quotient
);
    import rfa_pkg::*;

    localparam int CW = $clog2(DATA_W);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;

    assign mag_n   = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign mag_d   = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign shifted = {r_rem, r_q[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag_n;
            r_den <= mag_d;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_run) begin
            if (!diff[DATA_W+1]) begin
                r_rem <= diff[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_q + 1'b1) : r_q;

endmodule

// File: hw/rtl/rfa_dp.sv
// ----------------------------------------------------------------------------
// Register file ALU datapath
// Register file, operand decode, ALU, multiplier, divider and status flags.
// ----------------------------------------------------------------------------
module rfa_dp #(
    parameter int REG_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rfa_pkg::t_cmd                     i_cmd,
    output rfa_pkg::t_status                  o_status,
    input  logic [rfa_pkg::OP_W-1:0]          i_req_type,
    input  logic [rfa_pkg::IDX_W-1:0]         i_dest_reg,
    input  logic [rfa_pkg::IDX_W-1:0]         i_src_reg,
    input  logic signed [rfa_pkg::DATA_W-1:0] i_write_value,
    output logic signed [rfa_pkg::DATA_W-1:0] o_reg_value,
    output logic                              o_overflow_flag,
    output logic                              o_zero_flag,
    output logic                              o_sign_flag,
    output logic                              o_div_zero_error,
    output logic                              o_done
);
    import rfa_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    t_op                      r_op;
    logic [AW-1:0]            r_dest_addr;
    logic [AW-1:0]            r_src_addr;
    logic                     r_dest_ok;
    logic                     r_src_ok;
    logic [DATA_W-1:0]        r_wv;
    logic [REG_COUNT-1:0]     r_valid;
    t_flags                   r_flags;
    logic signed [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_reg_value;
    logic                     r_dz;
    logic                     r_done;

    logic [DATA_W-1:0]        rdata_a;
    logic [DATA_W-1:0]        rdata_b;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W-1:0]        quot;
    logic                     div_done;

    logic                     n_write;
    logic                     n_flag_upd;
    logic                     n_ovf;
    logic                     n_dz;
    logic [DATA_W-1:0]        n_res;
    logic                     n_finish;
    logic [DATA_W-1:0]        n_reg_value;
    logic                     we;
    logic [DATA_W-1:0]        sum;
    logic [DATA_W-1:0]        dif;

    rfa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_dest_addr),
        .i_wdata   (n_res),
        .i_re      (i_cmd.capture),
        .i_raddr_a (AW'(i_dest_reg)),
        .i_raddr_b (AW'(i_src_reg)),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    rfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (a),
        .i_divisor  (b),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign a   = (r_dest_ok && r_valid[r_dest_addr]) ? rdata_a : '0;
    assign b   = (r_src_ok && r_valid[r_src_addr]) ? rdata_b : '0;
    assign sum = a + b;
    assign dif = a - b;

    always_comb begin
        n_write    = 1'b0;
        n_flag_upd = 1'b0;
        n_ovf      = 1'b0;
        n_dz       = 1'b0;
        n_res      = r_wv;
        n_finish   = i_cmd.exec | i_cmd.mul_wb | i_cmd.div_wb;
        if (i_cmd.exec) begin
            unique case (r_op) inside
                OP_ADD: begin
                    n_res      = sum;
                    n_ovf      = (a[DATA_W-1] == b[DATA_W-1]) &&
                                 (sum[DATA_W-1] != a[DATA_W-1]);
                    n_flag_upd = 1'b1;
                    n_write    = 1'b1;
                end
                OP_SUB, OP_CMP: begin
                    n_res      = dif;
                    n_ovf      = (a[DATA_W-1] != b[DATA_W-1]) &&
                                 (dif[DATA_W-1] != a[DATA_W-1]);
                    n_flag_upd = 1'b1;
                    n_write    = (r_op == OP_SUB);
                end
                OP_DIV: begin
                    n_dz = 1'b1;
                end
                OP_MOV: begin
                    n_res   = b;
                    n_write = 1'b1;
                end
                OP_WRITE: begin
                    n_res   = r_wv;
                    n_write = 1'b1;
                end
                default: begin
                    n_res = r_wv;
                end
            endcase
        end else if (i_cmd.mul_wb) begin
            n_res      = r_prod[DATA_W-1:0];
            n_ovf      = (r_prod[2*DATA_W-1:DATA_W] != {DATA_W{r_prod[DATA_W-1]}});
            n_flag_upd = 1'b1;
            n_write    = 1'b1;
        end else if (i_cmd.div_wb) begin
            n_res      = quot;
            n_ovf      = (a == {1'b1, {(DATA_W-1){1'b0}}}) && (b == '1);
            n_flag_upd = 1'b1;
            n_write    = 1'b1;
        end
    end

    assign we = n_write && r_dest_ok;

    always_comb begin
        if (r_op == OP_WRITE) begin
            n_reg_value = r_wv;
        end else if (n_write) begin
            n_reg_value = r_dest_ok ? n_res : '0;
        end else begin
            n_reg_value = a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= t_op'(i_req_type);
            r_dest_addr <= AW'(i_dest_reg);
            r_src_addr  <= AW'(i_src_reg);
            r_dest_ok   <= (32'(i_dest_reg) < REG_COUNT);
            r_src_ok    <= (32'(i_src_reg) < REG_COUNT);
            r_wv        <= i_write_value;
        end
        r_prod <= a * b;
        if (n_finish) begin
            r_reg_value <= n_reg_value;
            r_dz        <= n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_flags <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_finish;
            if (we) begin
                r_valid[r_dest_addr] <= 1'b1;
            end
            if (n_flag_upd) begin
                r_flags.ovf  <= n_ovf;
                r_flags.zero <= (n_res == '0);
                r_flags.sign <= n_res[DATA_W-1];
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.div_zero = (b == '0);
    assign o_status.div_done = div_done;

    assign o_reg_value      = r_reg_value;
    assign o_overflow_flag  = r_flags.ovf;
    assign o_zero_flag      = r_flags.zero;
    assign o_sign_flag      = r_flags.sign;
    assign o_div_zero_error = r_dz;
    assign o_done           = r_done;

endmodule

// File: hw/rtl/rfa_ctrl.sv
// ----------------------------------------------------------------------------
// Register file ALU controller
// Sequences capture, execute, multiply write-back and divide iteration.
// ----------------------------------------------------------------------------
`include "register_file_alu_with_flags_top_macros.svh"

module rfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rfa_pkg::t_status i_status,
    output rfa_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import rfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (i_status.op == OP_DIV && !i_status.div_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_wb = 1'b1;
                n_state      = S_IDLE;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_wb = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `RFA_ASSERT_NEXT(a_accept_exec, i_start && (r_state == S_IDLE), r_state == S_EXEC, "accepted transaction did not enter execute")
    `RFA_ASSERT_NEXT(a_mul_one_cycle, r_state == S_MUL, r_state == S_IDLE, "multiply write-back overran")
    `RFA_ASSERT_NOW(a_div_done_in_div, i_status.div_done, r_state == S_DIV, "divider finished outside divide state")

endmodule

// File: hw/rtl/register_file_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// Register file ALU with status flags
// Register file, ALU and flags; one result transaction per accepted request.
// ----------------------------------------------------------------------------
// Sequence: a request is captured on acceptance and run in the execute state, the
// register file read being registered; mul adds a write-back state, div a divide
// state that waits on the iterative divider (one quotient bit per cycle), and a
// zero-divisor div ends in execute. A new request is accepted only in idle.
// Reset: synchronous, clears registers (per-entry valid bits), flags and control.
// The receiver cannot stall: o_done is a single-cycle strobe.
module register_file_alu_with_flags_top #(
    parameter int REG_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [rfa_pkg::OP_W-1:0]          i_req_type,
    input  logic [rfa_pkg::IDX_W-1:0]         i_dest_reg,
    input  logic [rfa_pkg::IDX_W-1:0]         i_src_reg,
    input  logic signed [rfa_pkg::DATA_W-1:0] i_write_value,
    output logic                              o_done,
    output logic signed [rfa_pkg::DATA_W-1:0] o_reg_value,
    output logic                              o_overflow_flag,
    output logic                              o_zero_flag,
    output logic                              o_sign_flag,
    output logic                              o_div_zero_error
);
    import rfa_pkg::*;

    t_cmd    cmd;
    t_status status;

    rfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    rfa_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req_type),
        .i_dest_reg       (i_dest_reg),
        .i_src_reg        (i_src_reg),
        .i_write_value    (i_write_value),
        .o_reg_value      (o_reg_value),
        .o_overflow_flag  (o_overflow_flag),
        .o_zero_flag      (o_zero_flag),
        .o_sign_flag      (o_sign_flag),
        .o_div_zero_error (o_div_zero_error),
        .o_done           (o_done)
    );

endmodule
